// File: hdl/bpa_pkg.sv
// Shared types, codes and helpers for the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int PAGE_SHIFT = 12;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_INIT  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOMEM   = 2'd1,
    STS_BADADDR = 2'd2
  } status_e;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_PCOUNT = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_ASRCH, ST_ASPLIT, ST_FRD, ST_FCHK,
    ST_FMRG, ST_FBUD, ST_FJOIN, ST_FEND, ST_PUSH1, ST_PUSH2, ST_UNL1,
    ST_UNL2, ST_FIN
  } state_e;

  // Smallest order whose page count covers the request.
  function automatic logic [3:0] order_for_pages(input logic [11:0] pages);
    logic [11:0] v;
    logic [3:0]  w;
    v = pages - 12'd1;
    w = 4'd0;
    if (pages > 12'd1) begin
      for (int i = 0; i < 12; i++) begin
        if (v[i]) w = 4'(i + 1);
      end
    end
    return w;
  endfunction

endpackage

// File: hdl/bpa_mem.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bpa_mem #(
  parameter int DW    = 8,
  parameter int AW    = 14,
  parameter int DEPTH = 16384
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/buddy_page_allocator.sv
// Buddy page allocator: 4 KiB pages, FIFO free list per order.
// Alloc searches the orders upward, then splits; free merges with buddies; init runs a
// metadata sweep, then creates blocks while stepping down the orders.
// One request at a time; the metadata and link RAMs set the pace, one read and one write
// per cycle each. Reset: asynchronous, active low; a clearing pass then runs over the page
// metadata, during which no request is taken (config writes land).
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 16384,
  parameter int TOP_ORDER = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [22:0] request_bytes_i,
  input  logic [31:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = PW + 1;                 // page index or empty marker
  localparam int OW = $clog2(TOP_ORDER + 1);
  localparam int MW = OW + 2;                 // {order, head, allocated}
  localparam int XW = ((LW > TOP_ORDER + 1) ? LW : TOP_ORDER + 1) + 1;
  localparam logic [LW-1:0] NONE = LW'(NUM_PAGES);

  // config registers
  logic [31:0] base_q;
  logic [14:0] pcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE:   base_q   <= cfg_data_i;
        CFG_PCOUNT: pcount_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e state_q, state_d, ret_q, ret_d;
  logic          init_q, init_d;
  logic [LW-1:0] cnt_q, cnt_d;         // clearing sweep
  logic [LW-1:0] managed_q, managed_d;
  logic [LW-1:0] cur_q, cur_d;         // page being worked on
  logic [LW-1:0] left_q, left_d;       // init: pages still to hand out
  logic [LW-1:0] node_q, node_d;       // list op target page
  logic [LW-1:0] oldl_q, oldl_d;       // old tail for push
  logic [LW-1:0] bud_q, bud_d;
  logic [OW-1:0] io_q, io_d;           // running order
  logic [OW-1:0] want_q, want_d;
  logic [OW-1:0] ord_q, ord_d;         // list op order
  logic [LW-1:0] first_q [TOP_ORDER+1];
  logic [LW-1:0] first_d [TOP_ORDER+1];
  logic [LW-1:0] last_q  [TOP_ORDER+1];
  logic [LW-1:0] last_d  [TOP_ORDER+1];
  logic [31:0]   addr_q, addr_d;
  status_e       sts_q, sts_d;

  // output register
  logic        ovld_q, ovld_d;
  logic [31:0] oaddr_q, oaddr_d;
  logic [1:0]  osts_q, osts_d;

  // RAM ports
  logic          m_we, n_we, p_we;
  logic [PW-1:0] m_wa, n_wa, p_wa, m_ra, l_ra;
  logic [MW-1:0] m_wd, m_rd;
  logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;

  bpa_mem #(.DW(MW), .AW(PW), .DEPTH(NUM_PAGES)) u_meta (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(m_wd), .raddr_i(m_ra), .rdata_o(m_rd)
  );
  bpa_mem #(.DW(LW), .AW(PW), .DEPTH(NUM_PAGES)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(l_ra), .rdata_o(n_rd)
  );
  bpa_mem #(.DW(LW), .AW(PW), .DEPTH(NUM_PAGES)) u_prev (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(l_ra), .rdata_o(p_rd)
  );

  // request decode
  logic [31:0] page_base, adiff;
  logic [23:0] bsum;
  logic [3:0]  want_w;
  logic        free_bad;
  assign page_base = {base_q[31:12], 12'h000};
  assign adiff     = block_address_i - page_base;
  assign bsum      = {1'b0, request_bytes_i} + 24'd4095;
  assign want_w    = order_for_pages(bsum[23:12]);
  assign free_bad  = (block_address_i[11:0] != 12'h000) || (block_address_i < page_base) ||
                     ({12'h000, adiff[31:12]} >= 32'(managed_q));

  // shared offset unit: page plus half a block / xor one block of the running order
  logic [XW-1:0] blk, blk_m1, sum_q1, xor_b;
  assign blk    = XW'(1) << io_q;
  assign blk_m1 = XW'(1) << (io_q - OW'(1));
  assign sum_q1 = XW'(cur_q) + blk_m1;
  assign xor_b  = XW'(cur_q) ^ blk;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    init_d    = init_q;
    cnt_d     = cnt_q;
    managed_d = managed_q;
    cur_d     = cur_q;
    left_d    = left_q;
    node_d    = node_q;
    oldl_d    = oldl_q;
    bud_d     = bud_q;
    io_d      = io_q;
    want_d    = want_q;
    ord_d     = ord_q;
    first_d   = first_q;
    last_d    = last_q;
    addr_d    = addr_q;
    sts_d     = sts_q;
    ovld_d    = ovld_q && !out_ready_i;
    oaddr_d   = oaddr_q;
    osts_d    = osts_q;
    m_we = 1'b0; m_wa = cur_q[PW-1:0]; m_wd = '0; m_ra = cur_q[PW-1:0];
    n_we = 1'b0; n_wa = node_q[PW-1:0]; n_wd = NONE;
    p_we = 1'b0; p_wa = node_q[PW-1:0]; p_wd = NONE;
    l_ra = node_q[PW-1:0];

    case (state_q)
      ST_CLEAR: begin
        m_we  = 1'b1;
        m_wa  = cnt_q[PW-1:0];
        m_wd  = '0;
        cnt_d = cnt_q + LW'(1);
        if (cnt_q == LW'(NUM_PAGES - 1)) state_d = init_q ? ST_INIT : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          addr_d = '0;
          sts_d  = STS_OK;
          case (func_i)
            FN_ALLOC: begin
              if (32'(want_w) > TOP_ORDER) begin
                sts_d   = STS_NOMEM;
                state_d = ST_FIN;
              end else begin
                want_d  = OW'(want_w);
                ord_d   = OW'(want_w);
                state_d = ST_ASRCH;
              end
            end
            FN_FREE: begin
              if (free_bad) begin
                sts_d   = STS_BADADDR;
                state_d = ST_FIN;
              end else begin
                cur_d   = LW'(adiff[31:12]);
                state_d = ST_FRD;
              end
            end
            FN_INIT: begin
              managed_d = (32'(pcount_q) < NUM_PAGES) ? LW'(pcount_q) : NONE;
              left_d    = (32'(pcount_q) < NUM_PAGES) ? LW'(pcount_q) : NONE;
              cur_d     = '0;
              io_d      = OW'(TOP_ORDER);
              for (int i = 0; i <= TOP_ORDER; i++) begin
                first_d[i] = NONE;
                last_d[i]  = NONE;
              end
              init_d  = 1'b1;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_INIT: begin
        init_d = 1'b0;
        if (XW'(left_q) >= blk) begin
          m_we    = 1'b1;
          m_wd    = {io_q, 1'b1, 1'b0};
          node_d  = cur_q;
          ord_d   = io_q;
          cur_d   = LW'(XW'(cur_q) + blk);
          left_d  = LW'(XW'(left_q) - blk);
          ret_d   = ST_INIT;
          state_d = ST_PUSH1;
        end else if (io_q == '0) begin
          state_d = ST_FIN;
        end else begin
          io_d = io_q - OW'(1);
        end
      end
      ST_ASRCH: begin
        if (first_q[ord_q] != NONE) begin
          node_d  = first_q[ord_q];
          cur_d   = first_q[ord_q];
          io_d    = ord_q;
          ret_d   = ST_ASPLIT;
          state_d = ST_UNL1;
        end else if (ord_q == OW'(TOP_ORDER)) begin
          sts_d   = STS_NOMEM;
          state_d = ST_FIN;
        end else begin
          ord_d = ord_q + OW'(1);
        end
      end
      ST_ASPLIT: begin
        if (io_q > want_q) begin
          io_d = io_q - OW'(1);
          if (sum_q1 < XW'(NUM_PAGES)) begin
            m_we    = 1'b1;
            m_wa    = sum_q1[PW-1:0];
            m_wd    = {io_q - OW'(1), 1'b1, 1'b0};
            node_d  = LW'(sum_q1);
            ord_d   = io_q - OW'(1);
            ret_d   = ST_ASPLIT;
            state_d = ST_PUSH1;
          end
        end else begin
          m_we    = 1'b1;
          m_wd    = {want_q, 1'b1, 1'b1};
          addr_d  = page_base + (32'(cur_q) << PAGE_SHIFT);
          state_d = ST_FIN;
        end
      end
      ST_FRD: state_d = ST_FCHK;   // metadata read of cur in flight
      ST_FCHK: begin
        if (!m_rd[1] || !m_rd[0]) begin
          sts_d   = STS_BADADDR;
          state_d = ST_FIN;
        end else begin
          m_we    = 1'b1;
          m_wd    = {m_rd[MW-1:2], 1'b1, 1'b0};
          io_d    = m_rd[MW-1:2];
          state_d = ST_FMRG;
        end
      end
      ST_FMRG: begin
        m_ra = xor_b[PW-1:0];
        if ((32'(io_q) < TOP_ORDER) && (xor_b < XW'(managed_q))) begin
          bud_d   = LW'(xor_b);
          state_d = ST_FBUD;
        end else begin
          state_d = ST_FEND;
        end
      end
      ST_FBUD: begin
        if (m_rd[1] && !m_rd[0] && (m_rd[MW-1:2] == io_q)) begin
          node_d  = bud_q;
          ord_d   = io_q;
          ret_d   = ST_FJOIN;
          state_d = ST_UNL1;
        end else begin
          state_d = ST_FEND;
        end
      end
      ST_FJOIN: begin
        m_we = 1'b1;
        m_wd = {io_q, 1'b0, 1'b0};
        if (bud_q > cur_q) begin
          m_wa = bud_q[PW-1:0];
        end else begin
          cur_d = bud_q;
        end
        io_d    = io_q + OW'(1);
        state_d = ST_FMRG;
      end
      ST_FEND: begin
        m_we    = 1'b1;
        m_wd    = {io_q, 1'b1, 1'b0};
        node_d  = cur_q;
        ord_d   = io_q;
        ret_d   = ST_FIN;
        state_d = ST_PUSH1;
      end
      ST_PUSH1: begin
        n_we   = 1'b1;
        n_wd   = NONE;
        p_we   = 1'b1;
        p_wd   = last_q[ord_q];
        oldl_d = last_q[ord_q];
        if (last_q[ord_q] == NONE) first_d[ord_q] = node_q;
        last_d[ord_q] = node_q;
        state_d = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (oldl_q != NONE) begin
          n_we = 1'b1;
          n_wa = oldl_q[PW-1:0];
          n_wd = node_q;
        end
        state_d = ret_q;
      end
      ST_UNL1: state_d = ST_UNL2;  // link reads of node in flight
      ST_UNL2: begin
        if (p_rd != NONE) begin
          n_we = 1'b1;
          n_wa = p_rd[PW-1:0];
          n_wd = n_rd;
        end else begin
          first_d[ord_q] = n_rd;
        end
        if (n_rd != NONE) begin
          p_we = 1'b1;
          p_wa = n_rd[PW-1:0];
          p_wd = p_rd;
        end else begin
          last_d[ord_q] = p_rd;
        end
        state_d = ret_q;
      end
      ST_FIN: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          oaddr_d = (sts_q == STS_OK) ? addr_q : '0;
          osts_d  = sts_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ret_q     <= ST_IDLE;
      init_q    <= 1'b0;
      cnt_q     <= '0;
      managed_q <= '0;
      ovld_q    <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
        first_q[i] <= NONE;
        last_q[i]  <= NONE;
      end
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      init_q    <= init_d;
      cnt_q     <= cnt_d;
      managed_q <= managed_d;
      ovld_q    <= ovld_d;
      first_q   <= first_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    left_q  <= left_d;
    node_q  <= node_d;
    oldl_q  <= oldl_d;
    bud_q   <= bud_d;
    io_q    <= io_d;
    want_q  <= want_d;
    ord_q   <= ord_d;
    addr_q  <= addr_d;
    sts_q   <= sts_d;
    oaddr_q <= oaddr_d;
    osts_q  <= osts_d;
  end

  assign out_valid_o      = ovld_q;
  assign result_address_o = oaddr_q;
  assign status_o         = osts_q;

endmodule

// File: hdl/bpa_checker.sv
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg.
module bpa_checker
  import bpa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_address_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_address_o))
    else $error("result dropped while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_OK) |-> result_address_o == 32'h0)
    else $error("failed request returned an address");

  a_page_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_address_o[11:0] == 12'h000)
    else $error("address not page aligned");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .result_address_o(result_address_o), .status_o(status_o)
);
